### rtl/acef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acef_pkg
// Shared constants, types and per-byte escape helpers for the cursor
// escape filter.
// ----------------------------------------------------------------------------
package acef_pkg;

  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRKT  = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [7:0] FILL_RST  = 8'h20;
  localparam logic [7:0] SMASH_RST = 8'h2D;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMASH = 2'd1;

  // output queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MAX_RES    = 3;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_ESC   = 2'd1,
    PH_PARAM = 2'd2
  } phase_t;

  function automatic logic is_param(input logic [7:0] b);
    return (b == CH_SEMI) || ((b >= CH_ZERO) && (b <= CH_NINE));
  endfunction

  function automatic logic is_command(input logic [7:0] b);
    return (b == "A") || (b == "B") || (b == "C") || (b == "D") || (b == "H") ||
           (b == "J") || (b == "K") || (b == "s") || (b == "u");
  endfunction

  function automatic phase_t esc_next(input phase_t ph, input logic [7:0] b);
    phase_t nxt;
    nxt = PH_TEXT;
    unique case (ph)
      PH_ESC: begin
        if (b == CH_LBRKT) nxt = PH_PARAM;
        else if (b == CH_ESC) nxt = PH_ESC;
        else nxt = PH_TEXT;
      end
      PH_PARAM: begin
        nxt = is_param(b) ? PH_PARAM : PH_TEXT;
      end
      default: begin
        nxt = (b == CH_ESC) ? PH_ESC : PH_TEXT;
      end
    endcase
    return nxt;
  endfunction

  function automatic logic [7:0] esc_out(input phase_t ph, input logic [7:0] b,
                                         input logic [7:0] fill);
    logic [7:0] o;
    o = b;
    if ((ph == PH_PARAM) && !is_param(b) && is_command(b)) o = fill;
    return o;
  endfunction

endpackage

### rtl/ansi_cursor_escape_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_cursor_escape_filter_top
// Byte stream filter: ">>" becomes ESC '[', "<<" becomes two smash bytes,
// and cursor/erase final bytes of ESC '[' sequences become the fill byte.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | in_byte, in_last
// out     | output    | out_valid / out_stall | out_byte, out_last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one input byte per cycle: a registered byte is filtered in one pass and
// its 0..3 results are written into an 8-entry output queue in the same cycle.
// the input register drains only when the queue has room for three results, so
// the queue read port (one result per cycle while out_stall is low) sets the
// sustained rate. reset (synchronous, rst_n low) empties the queue and clears
// all held state; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ansi_cursor_escape_filter_top
  import acef_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] fill_r, smash_r;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  logic   held_gt_r, held_gt_nxt;
  logic   held_lt_r, held_lt_nxt;
  phase_t phase_r, phase_nxt;

  logic [8:0]            fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;

  logic proc, pop;

  // front stages
  logic [7:0] t_byte [2];
  logic [1:0] t_n;
  logic [7:0] e_byte [MAX_RES];
  logic [1:0] e_n;
  logic [1:0] push_n;

  // escape stage
  phase_t     e_ph [MAX_RES];
  phase_t     ph_end;
  logic [7:0] o_byte [MAX_RES];
  logic       o_last [MAX_RES];

  assign cfg_ready = 1'b1;

  assign proc     = in_vld_r && (fifo_cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RES));
  assign in_stall = in_vld_r && !proc;
  assign pop      = out_valid && !out_stall;
  assign push_n   = proc ? e_n : 2'd0;

  assign out_valid = (fifo_cnt_r != '0);
  assign out_byte  = fifo_mem[rd_ptr_r][7:0];
  assign out_last  = fifo_mem[rd_ptr_r][8];

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) in_vld_nxt = 1'b1;
    else if (proc) in_vld_nxt = 1'b0;
  end

  // pair translation and pair smash
  always_comb begin
    t_byte[0]   = in_byte_r;
    t_byte[1]   = in_byte_r;
    t_n         = 2'd0;
    held_gt_nxt = held_gt_r;
    if (held_gt_r) begin
      held_gt_nxt = 1'b0;
      if (in_byte_r == CH_GT) begin
        t_byte[0] = CH_ESC;
        t_byte[1] = CH_LBRKT;
        t_n       = 2'd2;
      end else begin
        t_byte[0] = CH_GT;
        t_byte[1] = in_byte_r;
        t_n       = 2'd2;
      end
    end else if (in_byte_r == CH_GT) begin
      held_gt_nxt = 1'b1;
    end else begin
      t_byte[0] = in_byte_r;
      t_n       = 2'd1;
    end
    // end of string flushes a held '>'
    if (in_last_r && held_gt_nxt) begin
      held_gt_nxt    = 1'b0;
      t_byte[t_n[0]] = CH_GT;
      t_n            = t_n + 2'd1;
    end

    for (int i = 0; i < MAX_RES; i++) e_byte[i] = CH_LT;
    e_n         = 2'd0;
    held_lt_nxt = held_lt_r;
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < t_n) begin
        if (held_lt_nxt) begin
          held_lt_nxt = 1'b0;
          if (t_byte[k] == CH_LT) begin
            if (e_n != 2'd3) begin e_byte[e_n] = smash_r; e_n = e_n + 2'd1; end
            if (e_n != 2'd3) begin e_byte[e_n] = smash_r; e_n = e_n + 2'd1; end
          end else begin
            if (e_n != 2'd3) begin e_byte[e_n] = CH_LT; e_n = e_n + 2'd1; end
            if (e_n != 2'd3) begin e_byte[e_n] = t_byte[k]; e_n = e_n + 2'd1; end
          end
        end else if (t_byte[k] == CH_LT) begin
          held_lt_nxt = 1'b1;
        end else begin
          if (e_n != 2'd3) begin e_byte[e_n] = t_byte[k]; e_n = e_n + 2'd1; end
        end
      end
    end
    if (in_last_r && held_lt_nxt) begin
      held_lt_nxt = 1'b0;
      if (e_n != 2'd3) begin e_byte[e_n] = CH_LT; e_n = e_n + 2'd1; end
    end
  end

  // escape phase: next state
  always_comb begin
    ph_end = phase_r;
    for (int k = 0; k < MAX_RES; k++) begin
      e_ph[k] = ph_end;
      if (2'(k) < e_n) ph_end = esc_next(ph_end, e_byte[k]);
    end
    phase_nxt = in_last_r ? PH_TEXT : ph_end;
  end

  // escape phase: outputs
  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      o_byte[k] = esc_out(e_ph[k], e_byte[k], fill_r);
      o_last[k] = in_last_r && (2'(k) == (e_n - 2'd1));
    end
  end

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= FILL_RST;
      smash_r    <= SMASH_RST;
      in_vld_r   <= 1'b0;
      held_gt_r  <= 1'b0;
      held_lt_r  <= 1'b0;
      phase_r    <= PH_TEXT;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FILL) fill_r <= cfg_data;
        else if (cfg_index == CFG_SMASH) smash_r <= cfg_data;
      end
      in_vld_r <= in_vld_nxt;
      if (proc) begin
        held_gt_r <= held_gt_nxt;
        held_lt_r <= held_lt_nxt;
        phase_r   <= phase_nxt;
      end
      wr_ptr_r   <= wr_ptr_r + FIFO_PTR_W'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < push_n) fifo_mem[wr_ptr_r + FIFO_PTR_W'(k)] <= {o_last[k], o_byte[k]};
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r)
    else $error("stalled input register lost its byte");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_last_r) |=> (!held_gt_r && !held_lt_r && phase_r == PH_TEXT))
    else $error("state not cleared at end of string");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> (fifo_cnt_r + FIFO_CNT_W'(push_n) <= FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("push without room in output queue");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cursor escape filter. A queue-fed driver sends
// byte strings in random bursts, a receiver stalls on its own pattern, and a
// monitor compares every result transfer with a software image of the three
// filter stages. Fill and smash bytes are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top
  import acef_pkg::*;
();

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 105;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } stream_char_t;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  typedef enum int {
    TK_PLAIN,
    TK_GT_PAIR,
    TK_LT_PAIR,
    TK_CSI,
    TK_LONE,
    TK_ESC_ODD,
    TK_SMASH_ESC,
    TK_DIGITS
  } tok_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = 8'h00;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FILL;
  logic [7:0]           cfg_data = 8'h00;

  ansi_cursor_escape_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  stream_char_t pending_chars[$];
  stream_char_t expected_chars[$];
  stream_char_t step_out[$];
  stream_char_t word_buf[$];

  // filter image state
  logic [7:0] fill_reg  = FILL_RST;
  logic [7:0] smash_reg = SMASH_RST;
  logic       held_gt   = 1'b0;
  logic       held_lt   = 1'b0;
  phase_t     esc_phase = PH_TEXT;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // ---------------------------------------------------------------- filter image
  function automatic logic cursor_cmd(input logic [7:0] b);
    case (b)
      "A", "B", "C", "D", "H", "J", "K", "s", "u": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    if (step_out.size() < MAX_RES) step_out.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void escape_stage(input logic [7:0] b);
    if ((esc_phase == PH_ESC) && (b == CH_LBRKT)) begin
      esc_phase = PH_PARAM;
      emit_char(b);
    end else if (esc_phase == PH_PARAM) begin
      if ((b == CH_SEMI) || ((b >= CH_ZERO) && (b <= CH_NINE))) begin
        emit_char(b);
      end else begin
        // final byte is consumed here, never taken as a new ESC
        emit_char(cursor_cmd(b) ? fill_reg : b);
        esc_phase = PH_TEXT;
      end
    end else begin
      esc_phase = (b == CH_ESC) ? PH_ESC : PH_TEXT;
      emit_char(b);
    end
  endfunction

  function automatic void smash_stage(input logic [7:0] b);
    if (held_lt) begin
      held_lt = 1'b0;
      if (b == CH_LT) begin
        escape_stage(smash_reg);
        escape_stage(smash_reg);
      end else begin
        escape_stage(CH_LT);
        escape_stage(b);
      end
    end else if (b == CH_LT) begin
      held_lt = 1'b1;
    end else begin
      escape_stage(b);
    end
  endfunction

  function automatic void translate_stage(input logic [7:0] b);
    if (held_gt) begin
      held_gt = 1'b0;
      if (b == CH_GT) begin
        smash_stage(CH_ESC);
        smash_stage(CH_LBRKT);
      end else begin
        smash_stage(CH_GT);
        smash_stage(b);
      end
    end else if (b == CH_GT) begin
      held_gt = 1'b1;
    end else begin
      smash_stage(b);
    end
  endfunction

  function automatic void filter_step(input logic [7:0] b, input logic last);
    step_out.delete();
    translate_stage(b);
    if (last) begin
      // end of string flushes held bytes and drops any open sequence
      if (held_gt) begin
        held_gt = 1'b0;
        smash_stage(CH_GT);
      end
      if (held_lt) begin
        held_lt = 1'b0;
        escape_stage(CH_LT);
      end
      esc_phase = PH_TEXT;
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    end
    foreach (step_out[i]) expected_chars.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------- driver
  bit           in_taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  stream_char_t next_char;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: hold the payload
    end else begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        next_char = pending_chars.pop_front();
        in_valid <= 1'b1;
        in_byte  <= next_char.ch;
        in_last  <= next_char.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       rx_tick = 0;
  int       hold_left = 0;
  int       hold_req = 0;
  int       hold_seen = 0;

  always @(negedge clk) begin
    rx_tick++;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_COIN:     out_stall <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_stall <= ((rx_tick % 4) != 0);
        default:     out_stall <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  stream_char_t exp_char;
  bit           progress;

  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;
      if (in_valid && !in_stall) begin
        filter_step(in_byte, in_last);
        in_taken = 1'b1;
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transfer: expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last);
        end else begin
          exp_char = expected_chars.pop_front();
          if (out_byte !== exp_char.ch) begin
            mismatch_count++;
            $display("%0t: out_byte expected %02h actual %02h", $time, exp_char.ch, out_byte);
          end
          if (out_last !== exp_char.last) begin
            mismatch_count++;
            $display("%0t: out_last expected %0b actual %0b", $time, exp_char.last, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) progress = 1'b1;
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void put(input logic [7:0] c);
    word_buf.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void flush_word(input bit mark_last);
    if (mark_last && (word_buf.size() > 0)) word_buf[word_buf.size() - 1].last = 1'b1;
    foreach (word_buf[i]) pending_chars.push_back(word_buf[i]);
    word_buf.delete();
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 8))
      0: return "A";
      1: return "B";
      2: return "C";
      3: return "D";
      4: return "H";
      5: return "J";
      6: return "K";
      7: return "s";
      default: return "u";
    endcase
  endfunction

  function automatic logic [7:0] pick_param();
    return ($urandom_range(0, 3) == 0) ? CH_SEMI : CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void add_token();
    tok_kind_t kind;
    kind = tok_kind_t'($urandom_range(0, 7));
    case (kind)
      TK_PLAIN: repeat ($urandom_range(1, 3)) put(8'($urandom_range(1, 255)));
      TK_GT_PAIR: begin
        put(CH_GT);
        put(CH_GT);
      end
      TK_LT_PAIR: begin
        put(CH_LT);
        put(CH_LT);
      end
      TK_CSI: begin
        // introducer written directly or through the ">>" translation
        if ($urandom_range(0, 1) == 0) begin
          put(CH_ESC);
          put(CH_LBRKT);
        end else begin
          put(CH_GT);
          put(CH_GT);
        end
        repeat ($urandom_range(0, 3)) put(pick_param());
        put(($urandom_range(0, 2) != 0) ? pick_command() : 8'($urandom_range(1, 255)));
      end
      TK_LONE: put(($urandom_range(0, 1) == 0) ? CH_GT : CH_LT);
      TK_ESC_ODD: begin
        put(CH_ESC);
        case ($urandom_range(0, 3))
          0: put(CH_ESC);
          1: put(CH_GT);
          2: put(CH_LT);
          default: put(8'($urandom_range(1, 255)));
        endcase
      end
      TK_SMASH_ESC: begin
        put(CH_ESC);
        put(CH_LT);
        put(CH_LT);
      end
      default: repeat ($urandom_range(1, 4)) put(pick_param());
    endcase
  endfunction

  function automatic void add_random(input int target);
    int added;
    added = 0;
    while (added < target) begin
      if ($urandom_range(0, 99) < 15) begin
        // noise: raw bytes with string ends anywhere
        repeat ($urandom_range(1, 8))
          word_buf.push_back('{ch: 8'($urandom_range(1, 255)),
                               last: ($urandom_range(0, 3) == 0)});
        added += word_buf.size();
        flush_word(1'b0);
      end else begin
        repeat ($urandom_range(1, 5)) add_token();
        added += word_buf.size();
        flush_word(1'b1);
      end
    end
    add_token();
    flush_word(1'b1);
  endfunction

  task automatic wait_idle();
    while ((pending_chars.size() > 0) || in_valid || (expected_chars.size() > 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FILL) fill_reg = val;
    else smash_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed strings at reset register values
    put_str(">>1;5H");
    flush_word(1'b1);
    put_str("<<");
    flush_word(1'b1);
    put(CH_ESC);
    put(CH_LBRKT);
    put(CH_ESC);
    put_str("[u");
    flush_word(1'b1);
    put(CH_ESC);
    put_str("[3m");
    flush_word(1'b1);
    put_str("><");
    flush_word(1'b1);
    put(CH_ESC);
    put_str("[1");
    flush_word(1'b1);
    put_str("A");
    flush_word(1'b1);
    put(8'h00);
    flush_word(1'b1);
    put(8'hFF);
    flush_word(1'b1);
    wait_idle();

    write_reg(CFG_FILL, 8'h00);
    write_reg(CFG_SMASH, 8'hFF);
    add_random(PHASE_ITEMS);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    write_reg(CFG_FILL, 8'hFF);
    write_reg(CFG_SMASH, 8'h00);
    add_random(PHASE_ITEMS);
    hold_req++;
    wait_idle();

    write_reg(CFG_FILL, CH_ESC);
    write_reg(CFG_SMASH, CH_LT);
    add_random(PHASE_ITEMS);
    wait_idle();

    write_reg(CFG_FILL, CH_LBRKT);
    write_reg(CFG_SMASH, CH_ESC);
    add_random(PHASE_ITEMS);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
